FILE: hw/rtl/twg_pkg.sv
// Shared types and constants for the timestamp window grouper.
`default_nettype none
package twg_pkg;

  localparam int StampW    = 48;
  localparam int SpanW     = 47;
  localparam int IndexW    = 16;
  localparam int CountW    = 17;
  localparam int CfgIdxW   = 2;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = 2;
  localparam int QueueCntW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWindowStart = 2'd0,
    CfgWindowStop  = 2'd1,
    CfgGroupSpan   = 2'd2
  } cfg_reg_t;

  localparam logic signed [StampW-1:0] WindowStartReset = 48'sd0;
  localparam logic signed [StampW-1:0] WindowStopReset  = 48'sd86400000;
  localparam logic [SpanW-1:0]         GroupSpanReset   = 47'd3600000;

  typedef struct packed {
    logic [IndexW-1:0]        first_index;
    logic [CountW-1:0]        member_count;
    logic signed [StampW-1:0] group_begin;
    logic signed [StampW-1:0] group_finish;
    logic                     final_group;
  } result_t;

  // Up to two results written into the queue in one cycle, oldest in first.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } queue_write_t;

endpackage
`default_nettype wire

FILE: hw/rtl/timestamp_window_grouper_core.sv
// Timestamp window grouper: clusters a sorted event list into fixed-span groups.
// Takes one event per clock. The front end compares each event against the
// open group combinationally (one 49-bit subtract and four compares) and
// writes zero, one or two finished groups into a four-entry result queue.
// Input is taken while the queue has room for two results, else full is raised;
// each result is held in the queue and shown on the outputs once at its head.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user must
// write it only while idle, as the block does not enforce this.
`default_nettype none
module timestamp_window_grouper_core #(
  parameter longint unsigned LIST_CAPACITY = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [twg_pkg::StampW-1:0] start_stamp,
  input  logic signed [twg_pkg::StampW-1:0] finish_stamp,
  input  logic                              list_end,
  output logic                              empty,
  input  logic                              pop,
  output logic [twg_pkg::IndexW-1:0]        first_index,
  output logic [twg_pkg::CountW-1:0]        member_count,
  output logic signed [twg_pkg::StampW-1:0] group_begin,
  output logic signed [twg_pkg::StampW-1:0] group_finish,
  output logic                              final_group,
  input  logic                              cfg_write,
  input  logic [twg_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [twg_pkg::StampW-1:0]        cfg_data
);
  import twg_pkg::*;

  queue_write_t wr;
  logic         room;
  result_t      head;

  twg_front #(
    .LIST_CAPACITY(LIST_CAPACITY)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .start_stamp  (start_stamp),
    .finish_stamp (finish_stamp),
    .list_end     (list_end),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .room         (room),
    .wr           (wr)
  );

  twg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .room  (room),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  assign first_index  = head.first_index;
  assign member_count = head.member_count;
  assign group_begin  = head.group_begin;
  assign group_finish = head.group_finish;
  assign final_group  = head.final_group;

endmodule
`default_nettype wire

FILE: hw/rtl/twg_front.sv
// Front end: takes events, tracks the open group and produces group results.
`default_nettype none
module twg_front #(
  parameter longint unsigned LIST_CAPACITY = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [twg_pkg::StampW-1:0] start_stamp,
  input  logic signed [twg_pkg::StampW-1:0] finish_stamp,
  input  logic                              list_end,
  input  logic                              cfg_write,
  input  logic [twg_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [twg_pkg::StampW-1:0]        cfg_data,
  input  logic                              room,
  output twg_pkg::queue_write_t             wr
);
  import twg_pkg::*;

  localparam int PosW  = $clog2(LIST_CAPACITY);
  localparam int PosW1 = PosW + 1;
  localparam logic [PosW:0]   CapVal  = PosW1'(LIST_CAPACITY);
  localparam logic [PosW-1:0] LastPos = PosW'(LIST_CAPACITY - 1);

  logic signed [StampW-1:0] window_start;
  logic signed [StampW-1:0] window_stop;
  logic [SpanW-1:0]         group_span;

  logic                     open_flag;
  logic                     stopped_flag;
  logic [PosW-1:0]          pos;
  logic [PosW-1:0]          lead_index;
  logic signed [StampW-1:0] lead_stamp;
  logic signed [StampW-1:0] running_finish;

  logic                     open_next;
  logic                     stopped_next;
  logic [PosW-1:0]          lead_next;
  logic signed [StampW-1:0] stamp_next;
  logic signed [StampW-1:0] finish_next;

  logic                     accept;
  logic signed [StampW:0]   start_delta;
  logic                     close_hit;
  logic                     keep_hit;
  logic                     stop_hit;
  logic                     finish_grows;
  logic [PosW:0]            gap;
  logic [PosW:0]            end_cnt;
  logic                     do_close;
  logic                     close_final;
  logic                     end_emit;
  result_t                  close_rec;
  result_t                  end_rec;

  assign full   = !room;
  assign accept = push && !full;

  assign start_delta  = {start_stamp[StampW-1], start_stamp}
                      - {lead_stamp[StampW-1], lead_stamp};
  assign close_hit    = start_delta > $signed({2'b00, group_span});
  assign keep_hit     = start_stamp >= window_start;
  assign stop_hit     = start_stamp >= window_stop;
  assign finish_grows = finish_stamp > running_finish;

  // Distance from the group's first event, modulo the list capacity.
  always_comb begin
    if (pos >= lead_index) begin
      gap = {1'b0, pos} - {1'b0, lead_index};
    end else begin
      gap = {1'b0, pos} + CapVal - {1'b0, lead_index};
    end
  end

  always_comb begin
    open_next    = open_flag;
    stopped_next = stopped_flag;
    lead_next    = lead_index;
    stamp_next   = lead_stamp;
    finish_next  = running_finish;
    do_close     = 1'b0;
    close_final  = 1'b0;
    if (!stopped_flag) begin
      if (!open_flag) begin
        if (keep_hit) begin
          open_next   = 1'b1;
          lead_next   = pos;
          stamp_next  = start_stamp;
          finish_next = finish_stamp;
        end
      end else if (close_hit) begin
        do_close    = 1'b1;
        close_final = stop_hit;
        if (stop_hit) begin
          stopped_next = 1'b1;
          open_next    = 1'b0;
        end else begin
          lead_next   = pos;
          stamp_next  = start_stamp;
          finish_next = finish_stamp;
        end
      end else if (finish_grows) begin
        finish_next = finish_stamp;
      end
    end
  end

  assign end_emit = list_end && open_next && !stopped_next;
  // A group just opened by this event holds that event alone.
  assign end_cnt  = (do_close || !open_flag) ? PosW1'(1) : gap + PosW1'(1);

  always_comb begin
    close_rec.first_index  = IndexW'(lead_index);
    close_rec.member_count = CountW'(gap);
    close_rec.group_begin  = lead_stamp;
    close_rec.group_finish = running_finish;
    close_rec.final_group  = close_final;

    end_rec.first_index  = IndexW'(lead_next);
    end_rec.member_count = CountW'(end_cnt);
    end_rec.group_begin  = stamp_next;
    end_rec.group_finish = finish_next;
    end_rec.final_group  = 1'b1;

    wr.num    = accept ? (2'(do_close) + 2'(end_emit)) : 2'd0;
    wr.first  = do_close ? close_rec : end_rec;
    wr.second = end_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= WindowStartReset;
      window_stop  <= WindowStopReset;
      group_span   <= GroupSpanReset;
      open_flag    <= 1'b0;
      stopped_flag <= 1'b0;
      pos          <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          CfgWindowStart: window_start <= cfg_data;
          CfgWindowStop:  window_stop  <= cfg_data;
          CfgGroupSpan:   group_span   <= cfg_data[SpanW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (list_end) begin
          open_flag    <= 1'b0;
          stopped_flag <= 1'b0;
          pos          <= '0;
        end else begin
          open_flag    <= open_next;
          stopped_flag <= stopped_next;
          pos          <= (pos == LastPos) ? '0 : pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lead_index     <= lead_next;
      lead_stamp     <= stamp_next;
      running_finish <= finish_next;
    end
  end

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(open_flag && stopped_flag))
    else $error("group open while list is stopped");

  a_list_end_idle: assert property (@(posedge clk) disable iff (rst)
    accept && list_end |=> !open_flag && !stopped_flag && (pos == '0))
    else $error("front not idle after list end");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/twg_queue.sv
// Result queue: holds finished groups until the consumer pops them.
`default_nettype none
module twg_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  twg_pkg::queue_write_t wr,
  output logic                  room,
  input  logic                  pop,
  output logic                  empty,
  output twg_pkg::result_t      head
);
  import twg_pkg::*;

  result_t                slots [QueueDepth];
  logic [QueuePtrW-1:0]   wptr;
  logic [QueuePtrW-1:0]   rptr;
  logic [QueueCntW-1:0]   count;
  logic                   do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  // Keep room for the two results one event can produce.
  assign room   = count <= QueueCntW'(QueueDepth - 2);
  assign head   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QueuePtrW'(wr.num);
      rptr  <= rptr + QueuePtrW'(do_pop);
      count <= count + QueueCntW'(wr.num) - QueueCntW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.num != 2'd0) begin
      slots[wptr] <= wr.first;
    end
    if (wr.num == 2'd2) begin
      slots[wptr + QueuePtrW'(1)] <= wr.second;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QueueCntW'(QueueDepth))
    else $error("result queue overflow");

  a_write_has_room: assert property (@(posedge clk) disable iff (rst)
    wr.num != 2'd0 |-> count <= QueueCntW'(QueueDepth - 2) && wr.num != 2'd3)
    else $error("results written without room");
`endif

endmodule
`default_nettype wire
